@@ src/itp_pkg.sv @@
// Package for the infix to postfix converter: token and postfix item types,
// action, kind and status codes. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

	// Token actions.
	localparam logic [2:0] ACT_OPERAND  = 3'd0;
	localparam logic [2:0] ACT_OPERATOR = 3'd1;
	localparam logic [2:0] ACT_OPEN     = 3'd2;
	localparam logic [2:0] ACT_CLOSE    = 3'd3;
	localparam logic [2:0] ACT_END      = 3'd4;

	// Postfix item kinds.
	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_END      = 2'd2;

	// Status codes carried on end items.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNMATCHED = 2'd2;

	// Stack entry code of an opening parenthesis; operators are 0 to 3.
	localparam logic [2:0] PAREN_CODE = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  op_code;
		logic [31:0] value;
	} token_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  op_out;
		logic [31:0] value_out;
		logic [1:0]  status;
		logic        last;
	} pf_item_t;

endpackage

@@ src/itp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/itp_out_reg.sv @@
// Output register of the postfix item channel. Decouples the sequencer from
// downstream stalls. Depends on itp_pkg.
`timescale 1ns / 1ps

module itp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  itp_pkg::pf_item_t din,
	output logic             can_take,
	output logic             valid,
	input  logic             ready,
	output itp_pkg::pf_item_t dout
);

	import itp_pkg::*;

	logic     valid_q;
	pf_item_t item_q;

	// The register can load whenever it is empty or is being emptied now.
	assign can_take = !valid_q || ready;
	assign valid    = valid_q;
	assign dout     = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_take) begin
			item_q <= din;
		end
	end

endmodule

@@ src/infix_to_postfix_converter.sv @@
// Infix to postfix converter (shunting-yard) top level: sequencer, stack
// pointer and cached top. Depends on itp_pkg, itp_ram and itp_out_reg.
`timescale 1ns / 1ps

//  Channel   Direction  Payload      Handshake
//  token     in         token_t      token_valid / token_ready
//  item      out        pf_item_t    item_valid / item_ready
//
// A token is taken when the sequencer is idle, then worked on in steps:
// each step produces one postfix item, discards an opening parenthesis or
// does a push. The operator stack lives in a one-read, one-write RAM; the
// top entry is cached in a register and the entry below it is always
// prefetched, so one pop finishes every cycle unless the output register
// stalls. Reset clears the stack count and the sequencer; the RAM needs no
// clearing. A stalled output register holds the sequencer in place without
// losing work.

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_ready,
	input  itp_pkg::token_t   token,
	output logic              item_valid,
	input  logic              item_ready,
	output itp_pkg::pf_item_t item
);

	import itp_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WORK = 1'b1;

	logic          state_q;
	logic [2:0]    act_q;
	logic [1:0]    op_q;
	logic [31:0]   val_q;
	logic          paren_seen_q;
	logic [CW-1:0] count_q;
	logic [2:0]    tos_q;

	logic          accept;
	logic          empty, full, top_paren, below_ok;
	logic [2:0]    below;
	logic          emit, pop, push, done, set_paren, advance, can_take;
	logic [2:0]    push_code;
	pf_item_t      em_item;
	logic [CW-1:0] count_d;
	logic [CW-1:0] rd_ptr;

	assign token_ready = (state_q == S_IDLE);
	assign accept      = token_valid && token_ready;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign top_paren = tos_q[2];
	// The RAM read data holds the entry just below the cached top, when there is one.
	assign below_ok  = (count_q > CW'(1));

	// Decide what the current token does with the present top of stack.
	always_comb begin
		emit      = 1'b0;
		pop       = 1'b0;
		push      = 1'b0;
		done      = 1'b0;
		set_paren = 1'b0;
		push_code = {1'b0, op_q};
		em_item   = '{kind: KIND_OPERAND, op_out: 2'd0, value_out: 32'd0,
			status: ST_OK, last: 1'b0};
		if (state_q == S_WORK) begin
			case (act_q)
				ACT_OPERAND: begin
					emit              = 1'b1;
					em_item.value_out = val_q;
					em_item.last      = 1'b1;
					done              = 1'b1;
				end
				ACT_OPERATOR: begin
					if (!empty && !top_paren && (tos_q[1] >= op_q[1])) begin
						// Last only if the entry below will stop the popping.
						emit           = 1'b1;
						pop            = 1'b1;
						em_item.kind   = KIND_OPERATOR;
						em_item.op_out = tos_q[1:0];
						em_item.last   = !(below_ok && !below[2] && (below[1] >= op_q[1]));
					end else if (full) begin
						emit           = 1'b1;
						em_item.kind   = KIND_END;
						em_item.status = ST_OVERFLOW;
						em_item.last   = 1'b1;
						done           = 1'b1;
					end else begin
						push = 1'b1;
						done = 1'b1;
					end
				end
				ACT_OPEN: begin
					push_code = PAREN_CODE;
					if (full) begin
						emit           = 1'b1;
						em_item.kind   = KIND_END;
						em_item.status = ST_OVERFLOW;
						em_item.last   = 1'b1;
					end else begin
						push = 1'b1;
					end
					done = 1'b1;
				end
				ACT_CLOSE: begin
					if (empty) begin
						emit           = 1'b1;
						em_item.kind   = KIND_END;
						em_item.status = ST_UNMATCHED;
						em_item.last   = 1'b1;
						done           = 1'b1;
					end else if (top_paren) begin
						pop  = 1'b1;
						done = 1'b1;
					end else begin
						// Last only when the matching parenthesis sits just below.
						emit           = 1'b1;
						pop            = 1'b1;
						em_item.kind   = KIND_OPERATOR;
						em_item.op_out = tos_q[1:0];
						em_item.last   = below_ok && below[2];
					end
				end
				ACT_END: begin
					if (empty) begin
						emit           = 1'b1;
						em_item.kind   = KIND_END;
						em_item.status = paren_seen_q ? ST_UNMATCHED : ST_OK;
						em_item.last   = 1'b1;
						done           = 1'b1;
					end else if (top_paren) begin
						pop       = 1'b1;
						set_paren = 1'b1;
					end else begin
						emit           = 1'b1;
						pop            = 1'b1;
						em_item.kind   = KIND_OPERATOR;
						em_item.op_out = tos_q[1:0];
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	// Any step that produces an item waits for room in the output register.
	assign advance = !emit || can_take;

	always_comb begin
		count_d = count_q;
		if (advance && pop) begin
			count_d = count_q - CW'(1);
		end else if (advance && push) begin
			count_d = count_q + CW'(1);
		end
	end

	// Prefetch the entry that will sit below the top after this cycle.
	assign rd_ptr = count_d - CW'(2);

	itp_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (advance && push),
		.waddr (count_q[AW-1:0]),
		.wdata (push_code),
		.raddr (rd_ptr[AW-1:0]),
		.rdata (below)
	);

	itp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.din      (em_item),
		.can_take (can_take),
		.valid    (item_valid),
		.ready    (item_ready),
		.dout     (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			act_q        <= ACT_OPERAND;
			paren_seen_q <= 1'b0;
			count_q      <= '0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				state_q      <= S_WORK;
				act_q        <= token.action;
				paren_seen_q <= 1'b0;
			end else if (advance) begin
				if (done) begin
					state_q <= S_IDLE;
				end
				if (set_paren) begin
					paren_seen_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers: token operands and the cached top of stack.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= token.op_code;
			val_q <= token.value;
		end
		if (advance && pop) begin
			tos_q <= below;
		end else if (advance && push) begin
			tos_q <= push_code;
		end
	end

	// The stack count never exceeds the stack depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	// An end item always closes the items of its token.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit && (em_item.kind == KIND_END) |-> em_item.last)
		else $error("end item without last");

	// Error status appears only on end items.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit && (em_item.status != ST_OK) |-> (em_item.kind == KIND_END))
		else $error("status on a non-end item");

	// A pop and a push never happen in the same step, and neither while idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop || push) |-> (!(pop && push) && (state_q == S_WORK)))
		else $error("illegal stack operation");

endmodule
